[rtl/core/imm_pkg.sv]
// Shared types, sizes and helpers for the integer matrix multiply block.
// Depends on nothing; every other file but imm_ram refers to it by scoped names.
package imm_pkg;

    localparam int DIM = 4;
    localparam int IDX_W = (DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int CNT_W = 3;
    localparam int VAL_W = 16;
    localparam int MUL_W = 32;
    localparam int ACC_W = 36;

    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_START      = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIM - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_left;
        logic             wr_right;
        logic             issue;
        logic             k_first;
        logic             k_last;
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] k;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } stat_t;

    function automatic logic [IDX_W-1:0] idx(input logic [CNT_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
        logic [6:0] flat;
        flat = 7'(r) * 7'(DIM) + 7'(c);
        return flat[IDX_W-1:0];
    endfunction

endpackage

[rtl/core/imm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module imm_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/imm_datapath.sv]
// Datapath: operand stores, multiply stage, accumulator and output register.
// Depends on imm_pkg and imm_ram.
module imm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::cmd_t                 cmd,
    output imm_pkg::stat_t                stat,
    input  logic [imm_pkg::CNT_W-1:0]     row,
    input  logic [imm_pkg::CNT_W-1:0]     col,
    input  logic signed [imm_pkg::VAL_W-1:0] value,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [imm_pkg::CNT_W-1:0]     out_row,
    output logic [imm_pkg::CNT_W-1:0]     out_col,
    output logic signed [imm_pkg::ACC_W-1:0] product,
    output logic                          last
);

    logic [imm_pkg::IDX_W-1:0] wr_idx;
    logic [imm_pkg::IDX_W-1:0] left_raddr;
    logic [imm_pkg::IDX_W-1:0] right_raddr;
    logic signed [imm_pkg::VAL_W-1:0] left_q;
    logic signed [imm_pkg::VAL_W-1:0] right_q;

    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [imm_pkg::MUL_W-1:0] mul_reg;
    logic signed [imm_pkg::ACC_W-1:0] acc_reg;
    logic signed [imm_pkg::ACC_W-1:0] acc_next;

    logic                                out_valid_reg, out_valid_next;
    logic [imm_pkg::CNT_W-1:0]           out_row_reg, out_col_reg;
    logic signed [imm_pkg::ACC_W-1:0]    product_reg;
    logic                                last_reg;

    assign wr_idx      = imm_pkg::idx(row, col);
    assign left_raddr  = imm_pkg::idx(cmd.i, cmd.k);
    assign right_raddr = imm_pkg::idx(cmd.k, cmd.j);

    imm_ram #(
        .WIDTH (imm_pkg::VAL_W),
        .DEPTH (imm_pkg::DIM * imm_pkg::DIM)
    ) u_left_ram (
        .clk   (clk),
        .we    (cmd.wr_left),
        .waddr (wr_idx),
        .wdata (value),
        .raddr (left_raddr),
        .rdata (left_q)
    );

    imm_ram #(
        .WIDTH (imm_pkg::VAL_W),
        .DEPTH (imm_pkg::DIM * imm_pkg::DIM)
    ) u_right_ram (
        .clk   (clk),
        .we    (cmd.wr_right),
        .waddr (wr_idx),
        .wdata (value),
        .raddr (right_raddr),
        .rdata (right_q)
    );

    // First term of a dot product restarts the sum.
    assign acc_next = (s2_first_reg ? '0 : acc_reg) + imm_pkg::ACC_W'(mul_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s2_valid_reg && s2_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.k_first;
        s1_last_reg  <= cmd.k_last;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        mul_reg      <= imm_pkg::MUL_W'(left_q * right_q);
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_last_reg)
        begin
            product_reg <= acc_next;
            out_row_reg <= cmd.i;
            out_col_reg <= cmd.j;
            last_reg    <= (cmd.i == imm_pkg::CNT_LAST) && (cmd.j == imm_pkg::CNT_LAST);
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_row        = out_row_reg;
    assign out_col        = out_col_reg;
    assign product        = product_reg;
    assign last           = last_reg;

endmodule

[rtl/core/imm_ctrl.sv]
// Controller: input acceptance, element and term sequencing for the multiply.
// Depends on imm_pkg.
module imm_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [imm_pkg::CNT_W-1:0] row,
    input  logic [imm_pkg::CNT_W-1:0] col,
    input  logic                      out_stall,
    output imm_pkg::cmd_t             cmd,
    input  imm_pkg::stat_t            stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [imm_pkg::CNT_W-1:0] i_reg, i_next;
    logic [imm_pkg::CNT_W-1:0] j_reg, j_next;
    logic [imm_pkg::CNT_W-1:0] k_reg, k_next;
    logic                      in_take;
    logic                      in_range;
    logic                      out_take;
    logic                      final_elem;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign in_range   = (32'(row) < imm_pkg::DIM) && (32'(col) < imm_pkg::DIM);
    assign out_take   = stat.out_valid && !out_stall;
    assign final_elem = (i_reg == imm_pkg::CNT_LAST) && (j_reg == imm_pkg::CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && op == imm_pkg::OP_START)
                begin
                    state_next = ST_ISSUE;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == imm_pkg::CNT_LAST)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                // Advance to the next element once the result transaction completes.
                if (out_take)
                begin
                    k_next = '0;
                    if (final_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == imm_pkg::CNT_LAST)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.wr_left  = in_take && in_range && (op == imm_pkg::OP_LOAD_LEFT);
        cmd.wr_right = in_take && in_range && (op == imm_pkg::OP_LOAD_RIGHT);
        cmd.issue    = (state_reg == ST_ISSUE);
        cmd.k_first  = (k_reg == '0);
        cmd.k_last   = (k_reg == imm_pkg::CNT_LAST);
        cmd.i        = i_reg;
        cmd.j        = j_reg;
        cmd.k        = k_reg;
    end

    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_valid |-> (state_reg == ST_WAIT))
        else $error("result valid outside wait state");

    a_start_begins: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && op == imm_pkg::OP_START) |=>
        (state_reg == ST_ISSUE && i_reg == '0 && j_reg == '0 && k_reg == '0))
        else $error("start did not begin at element zero");

    a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && out_take && final_elem) |=> (state_reg == ST_IDLE))
        else $error("final element did not return to idle");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(cmd.wr_left || cmd.wr_right))
        else $error("store written during multiply");

endmodule

[rtl/core/integer_matrix_multiply.sv]
// Integer matrix multiply top level: DIM x DIM product of two loaded matrices.
// Load transactions are accepted back to back while no multiply is running.
// A start transaction stalls the input while one MAC unit walks all elements:
// each element issues DIM term reads, which pass through read, multiply and sum,
// and the next element starts only once the output has taken the result.
// Reset clears control state only; the operand stores hold garbage until loaded.
module integer_matrix_multiply (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [imm_pkg::CNT_W-1:0]        row,
    input  logic [imm_pkg::CNT_W-1:0]        col,
    input  logic signed [imm_pkg::VAL_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [imm_pkg::CNT_W-1:0]        out_row,
    output logic [imm_pkg::CNT_W-1:0]        out_col,
    output logic signed [imm_pkg::ACC_W-1:0] product,
    output logic                             last
);

    imm_pkg::cmd_t  cmd;
    imm_pkg::stat_t stat;

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    imm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .product   (product),
        .last      (last)
    );

endmodule

[tb/tb_integer_matrix_multiply.sv]
// Self-checking testbench for integer_matrix_multiply: loads both matrices, starts
// multiplies and checks every product element against a behavioral matrix product.
// Depends on imm_pkg for sizes and opcodes, and on the integer_matrix_multiply RTL.
module tb_integer_matrix_multiply;

    localparam int DIM   = imm_pkg::DIM;
    localparam int CNT_W = imm_pkg::CNT_W;
    localparam int VAL_W = imm_pkg::VAL_W;
    localparam int ACC_W = imm_pkg::ACC_W;
    localparam logic [1:0] OP_LOAD_LEFT  = imm_pkg::OP_LOAD_LEFT;
    localparam logic [1:0] OP_LOAD_RIGHT = imm_pkg::OP_LOAD_RIGHT;
    localparam logic [1:0] OP_START      = imm_pkg::OP_START;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int ELEM_CYCLES = DIM + 3;

    typedef struct {
        logic [CNT_W-1:0]        r;
        logic [CNT_W-1:0]        c;
        logic signed [ACC_W-1:0] prod;
        logic                    is_last;
    } product_elem_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              op = OP_LOAD_LEFT;
    logic [CNT_W-1:0]        row = '0;
    logic [CNT_W-1:0]        col = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [CNT_W-1:0]        out_row;
    logic [CNT_W-1:0]        out_col;
    logic signed [ACC_W-1:0] product;
    logic                    last;

    logic signed [VAL_W-1:0] left_mat [DIM*DIM];
    logic signed [VAL_W-1:0] right_mat [DIM*DIM];
    product_elem_t           pending_products [$];
    int                      mismatch_count = 0;
    int                      out_stall_left = 0;
    bit                      send_back_to_back = 1'b0;
    bit                      drain_back_to_back = 1'b0;

    integer_matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .product   (product),
        .last      (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Update the operand copies on loads; expand a start into the whole product.
    task automatic predict_transaction(input logic [1:0] o, input logic [CNT_W-1:0] r,
                                       input logic [CNT_W-1:0] c,
                                       input logic signed [VAL_W-1:0] v);
        product_elem_t e;
        longint        acc;
        case (o)
            OP_LOAD_LEFT:
            begin
                if (r < DIM && c < DIM)
                    left_mat[int'(r) * DIM + int'(c)] = v;
            end
            OP_LOAD_RIGHT:
            begin
                if (r < DIM && c < DIM)
                    right_mat[int'(r) * DIM + int'(c)] = v;
            end
            OP_START:
            begin
                for (int i = 0; i < DIM; i++)
                begin
                    for (int j = 0; j < DIM; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < DIM; k++)
                            acc += longint'(left_mat[i * DIM + k]) *
                                   longint'(right_mat[k * DIM + j]);
                        e.r       = CNT_W'(i);
                        e.c       = CNT_W'(j);
                        e.prod    = acc[ACC_W-1:0];
                        e.is_last = (i == DIM - 1 && j == DIM - 1);
                        pending_products.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Present one transaction after a random gap (none when sending back to back) and hold it until accepted.
    task automatic send_transaction(input logic [1:0] o, input logic [CNT_W-1:0] r,
                                    input logic [CNT_W-1:0] c,
                                    input logic signed [VAL_W-1:0] v);
        int gap;
        gap = send_back_to_back ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        row      <= r;
        col      <= c;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        predict_transaction(o, r, c, v);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Mostly in range; now and then anywhere the field allows.
    function automatic logic [CNT_W-1:0] rand_index();
        if ($urandom_range(0, 9) == 0)
            return CNT_W'($urandom_range(0, 7));
        return CNT_W'($urandom_range(0, DIM - 1));
    endfunction

    // Check each product element as it leaves; draw the next output stall.
    always @(posedge clk)
    begin
        product_elem_t e;
        int            gap;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_products.size() == 0)
                begin
                    $error("unexpected product element row=%0d col=%0d product=%0d",
                           out_row, out_col, product);
                    mismatch_count++;
                end
                else
                begin
                    e = pending_products.pop_front();
                    if (out_row !== e.r)
                    begin
                        $error("out_row expected %0d actual %0d", e.r, out_row);
                        mismatch_count++;
                    end
                    if (out_col !== e.c)
                    begin
                        $error("out_col expected %0d actual %0d", e.c, out_col);
                        mismatch_count++;
                    end
                    if (product !== e.prod)
                    begin
                        $error("product expected %0d actual %0d", e.prod, product);
                        mismatch_count++;
                    end
                    if (last !== e.is_last)
                    begin
                        $error("last expected %0d actual %0d", e.is_last, last);
                        mismatch_count++;
                    end
                end
                gap = drain_back_to_back ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    out_stall      <= 1'b1;
                    out_stall_left = gap;
                end
            end
            else if (out_stall)
            begin
                out_stall_left--;
                if (out_stall_left <= 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Both operands at the most negative value: every element is the largest sum.
    task automatic test_fill_extremes();
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                send_transaction(OP_LOAD_LEFT, CNT_W'(r), CNT_W'(c), VAL_MIN);
                send_transaction(OP_LOAD_RIGHT, CNT_W'(r), CNT_W'(c), VAL_MIN);
            end
        end
        send_transaction(OP_START, '0, '0, '0);
    endtask

    // Max positive row against most negative columns gives the lowest sums; right (DIM-1,DIM-1) becomes -1.
    task automatic test_mixed_signs();
        for (int c = 0; c < DIM; c++)
            send_transaction(OP_LOAD_LEFT, '0, CNT_W'(c), VAL_MAX);
        if (DIM > 1)
            send_transaction(OP_LOAD_LEFT, CNT_W'(1), '0, '0);
        send_transaction(OP_LOAD_RIGHT, CNT_W'(DIM - 1), CNT_W'(DIM - 1), '1);
        send_transaction(OP_START, '1, '1, '1);
    endtask

    // Out-of-range loads and the unused opcode must leave the stores alone.
    task automatic test_ignored_items();
        send_transaction(OP_LOAD_LEFT, '1, '0, 16'sh5555);
        send_transaction(OP_LOAD_RIGHT, '0, '1, 16'sh2aaa);
        send_transaction(OP_LOAD_LEFT, CNT_W'(DIM % 8), CNT_W'(DIM % 8), VAL_MAX);
        send_transaction(OP_UNUSED, '1, '1, '1);
        send_transaction(OP_START, '1, '0, VAL_MIN);
    endtask

    // Two consecutive starts each repeat the full product.
    task automatic test_repeated_start();
        send_transaction(OP_START, '0, '1, VAL_MAX);
        send_transaction(OP_START, '1, '1, '0);
    endtask

    // Hold off the sender until every pending product element has drained.
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        send_transaction(OP_LOAD_RIGHT, '0, '0, VAL_MAX);
        send_transaction(OP_START, '0, '0, '0);
    endtask

    // Load bursts of random content, each closed by a start.
    task automatic test_random_bursts(input int n_items);
        int               sent;
        int               loads;
        logic [1:0]       o;
        logic [CNT_W-1:0] r;
        logic [CNT_W-1:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            loads = $urandom_range(1, 10);
            for (int k = 0; k < loads; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    o = OP_UNUSED;
                else
                    o = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
                r = rand_index();
                c = rand_index();
                send_transaction(o, r, c, rand_value());
                if (o != OP_UNUSED && r < DIM && c < DIM)
                    sent++;
            end
            send_transaction(OP_START, CNT_W'($urandom), CNT_W'($urandom), rand_value());
            sent++;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_extremes();
        test_mixed_signs();
        test_ignored_items();
        test_repeated_start();
        test_random_bursts(36);
        test_drain_pause();
        send_back_to_back  = 1'b1;
        drain_back_to_back = 1'b1;
        test_random_bursts(18);
        send_back_to_back  = 1'b0;
        drain_back_to_back = 1'b0;
        test_random_bursts(18);

        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        // Leave room for any stray element to show up.
        repeat (4 * ELEM_CYCLES + 16) @(posedge clk);

        if (pending_products.size() != 0)
        begin
            $error("%0d product elements never arrived", pending_products.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
